@@ rtl/imq_pkg.sv @@
// Shared constants, status codes and entry type for the indexed min priority queue.
`default_nettype none

package imq_pkg;

    localparam int CAPACITY = 256;
    localparam int ID_W     = 8;
    localparam int PRI_W    = 32;
    localparam int SLOT_W   = 9;
    localparam int ADDR_W   = 8;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = ID_W + PRI_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_EMPTY,
        ST_FULL,
        ST_RANGE,
        ST_ABSENT,
        ST_PRESENT,
        ST_NOT_LOWER
    } status_t;

    localparam logic [KIND_W-1:0] KIND_INSERT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EXTRACT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DECREASE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GET      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PEEK     = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [PRI_W-1:0] pri;
    } entry_t;

endpackage

`default_nettype wire

@@ rtl/imq_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none

module imq_ram #(
    parameter int DATA_W = 40,
    parameter int ADDR_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] wa,
    input  wire logic [DATA_W-1:0] wd,
    input  wire logic [ADDR_W-1:0] ra,
    output logic      [DATA_W-1:0] rd
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd <= mem[ra];
    end

endmodule

`default_nettype wire

@@ rtl/indexed_min_priority_queue.sv @@
// Top level of the indexed binary min-heap with decrease-key.
//
//   Channel  Handshake               Payload
//   in       in_valid / in_ready     kind, id, priority_req
//   out      out_valid / out_ready   status, out_id, out_priority, entry_count
//   cfg      cfg_we                  cfg_wdata (capacity_in_use)
//
// One item is worked at a time: the lookup passes through S_LOOK and S_CHK after
// acceptance, each heap level of a sift up through S_UPRD and S_UPCMP and each level
// of a sift down through S_DNRL, S_DNRR and S_DNCMP, since the single heap RAM read
// port is shared by parent and both children.
// Reset clears the id map valid bits at once; no clearing pass is needed.
// A new item is taken while the previous result waits in the output register.
`default_nettype none

module indexed_min_priority_queue (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [imq_pkg::KIND_W-1:0]      kind,
    input  wire logic [imq_pkg::ID_W-1:0]        id,
    input  wire logic signed [imq_pkg::PRI_W-1:0] priority_req,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [imq_pkg::STATUS_W-1:0]         status,
    output logic [imq_pkg::ID_W-1:0]             out_id,
    output logic signed [imq_pkg::PRI_W-1:0]     out_priority,
    output logic [imq_pkg::SLOT_W-1:0]           entry_count,
    input  wire logic                            cfg_we,
    input  wire logic [imq_pkg::SLOT_W-1:0]      cfg_wdata
);

    import imq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_CHK,
        S_EXLAST,
        S_DGCMP,
        S_UPRD,
        S_UPCMP,
        S_DNRL,
        S_DNRR,
        S_DNCMP,
        S_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [KIND_W-1:0]        kind_reg, kind_next;
    logic [ID_W-1:0]          id_reg, id_next;
    logic signed [PRI_W-1:0]  req_reg, req_next;
    logic [SLOT_W-1:0]        count_reg, count_next;
    logic [SLOT_W-1:0]        cap_reg, cap_next;
    logic [SLOT_W-1:0]        s_reg, s_next;
    entry_t                   cur_reg, cur_next;
    entry_t                   left_reg, left_next;
    logic                     rok_reg, rok_next;
    status_t                  res_status_reg, res_status_next;
    logic [ID_W-1:0]          res_id_reg, res_id_next;
    logic signed [PRI_W-1:0]  res_pri_reg, res_pri_next;
    logic                     out_valid_reg, out_valid_next;
    status_t                  status_reg, status_next;
    logic [ID_W-1:0]          out_id_reg, out_id_next;
    logic signed [PRI_W-1:0]  out_pri_reg, out_pri_next;
    logic [SLOT_W-1:0]        entry_count_reg, entry_count_next;

    logic                     heap_we;
    logic [ADDR_W-1:0]        heap_wa, heap_ra;
    entry_t                   heap_wd, heap_q;
    logic [ENTRY_W-1:0]       heap_rd;

    logic [SLOT_W-1:0]        pos_mem [CAPACITY];
    logic [CAPACITY-1:0]      pos_valid_reg;
    logic                     pos_we;
    logic [ADDR_W-1:0]        pos_wa;
    logic [SLOT_W-1:0]        pos_wd;
    logic [SLOT_W-1:0]        pos_q;
    logic                     pos_vq;

    logic [SLOT_W-1:0]        cap;
    logic [SLOT_W-1:0]        posv;
    logic [SLOT_W:0]          lslot, rslot, count_ext;
    logic [SLOT_W-1:0]        parent;
    logic signed [PRI_W-1:0]  best_pri;
    logic                     take_l, take_r;

    imq_ram #(
        .DATA_W (ENTRY_W),
        .ADDR_W (ADDR_W)
    ) u_heap (
        .clk (clk),
        .we  (heap_we),
        .wa  (heap_wa),
        .wd  (heap_wd),
        .ra  (heap_ra),
        .rd  (heap_rd)
    );

    assign heap_q = entry_t'(heap_rd);

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_wa] <= pos_wd;
        end
        pos_q <= pos_mem[id_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_valid_reg <= '0;
            pos_vq        <= 1'b0;
        end
        else
        begin
            if (pos_we)
            begin
                pos_valid_reg[pos_wa] <= 1'b1;
            end
            pos_vq <= pos_valid_reg[id_reg];
        end
    end

    assign cap       = (cap_reg > SLOT_W'(CAPACITY)) ? SLOT_W'(CAPACITY) : cap_reg;
    assign posv      = pos_vq ? pos_q : '0;
    assign lslot     = {s_reg, 1'b0};
    assign rslot     = {s_reg, 1'b1};
    assign count_ext = {1'b0, count_reg};
    assign parent    = s_reg >> 1;
    assign take_l    = left_reg.pri < cur_reg.pri;
    assign best_pri  = take_l ? left_reg.pri : cur_reg.pri;
    assign take_r    = rok_reg && (heap_q.pri < best_pri);

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_id       = out_id_reg;
    assign out_priority = out_pri_reg;
    assign entry_count  = entry_count_reg;

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        id_next          = id_reg;
        req_next         = req_reg;
        count_next       = count_reg;
        cap_next         = cfg_we ? cfg_wdata : cap_reg;
        s_next           = s_reg;
        cur_next         = cur_reg;
        left_next        = left_reg;
        rok_next         = rok_reg;
        res_status_next  = res_status_reg;
        res_id_next      = res_id_reg;
        res_pri_next     = res_pri_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        out_id_next      = out_id_reg;
        out_pri_next     = out_pri_reg;
        entry_count_next = entry_count_reg;
        heap_we          = 1'b0;
        heap_wa          = ADDR_W'(s_reg - SLOT_W'(1));
        heap_wd          = cur_reg;
        heap_ra          = '0;
        pos_we           = 1'b0;
        pos_wa           = cur_reg.id;
        pos_wd           = s_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next       = kind;
                    id_next         = id;
                    req_next        = priority_req;
                    res_status_next = ST_OK;
                    res_id_next     = id;
                    res_pri_next    = '0;
                    state_next      = S_LOOK;
                end
            end
            S_LOOK:
            begin
                heap_ra    = '0;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = S_DONE;
                unique case (kind_reg)
                    KIND_INSERT:
                    begin
                        if ({1'b0, id_reg} >= cap)
                        begin
                            res_status_next = ST_RANGE;
                        end
                        else if (posv != '0)
                        begin
                            res_status_next = ST_PRESENT;
                        end
                        else if (count_reg >= cap)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            count_next   = count_reg + SLOT_W'(1);
                            s_next       = count_reg + SLOT_W'(1);
                            cur_next     = '{id: id_reg, pri: req_reg};
                            res_pri_next = req_reg;
                            state_next   = S_UPRD;
                        end
                    end
                    KIND_EXTRACT:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            res_id_next  = heap_q.id;
                            res_pri_next = heap_q.pri;
                            pos_we       = 1'b1;
                            pos_wa       = heap_q.id;
                            pos_wd       = '0;
                            if (count_reg == SLOT_W'(1))
                            begin
                                count_next = '0;
                            end
                            else
                            begin
                                heap_ra    = ADDR_W'(count_reg - SLOT_W'(1));
                                state_next = S_EXLAST;
                            end
                        end
                    end
                    KIND_DECREASE, KIND_GET:
                    begin
                        if ({1'b0, id_reg} >= cap)
                        begin
                            res_status_next = ST_RANGE;
                        end
                        else if (posv == '0 || posv > count_reg)
                        begin
                            res_status_next = ST_ABSENT;
                        end
                        else
                        begin
                            s_next     = posv;
                            heap_ra    = ADDR_W'(posv - SLOT_W'(1));
                            state_next = S_DGCMP;
                        end
                    end
                    default:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            res_id_next  = heap_q.id;
                            res_pri_next = heap_q.pri;
                        end
                    end
                endcase
            end
            S_EXLAST:
            begin
                cur_next   = heap_q;
                count_next = count_reg - SLOT_W'(1);
                s_next     = SLOT_W'(1);
                state_next = S_DNRL;
            end
            S_DGCMP:
            begin
                state_next = S_DONE;
                if (kind_reg == KIND_GET)
                begin
                    res_pri_next = heap_q.pri;
                end
                else if (heap_q.pri <= req_reg)
                begin
                    res_status_next = ST_NOT_LOWER;
                end
                else
                begin
                    cur_next     = '{id: id_reg, pri: req_reg};
                    res_pri_next = req_reg;
                    state_next   = S_UPRD;
                end
            end
            S_UPRD:
            begin
                if (s_reg == SLOT_W'(1))
                begin
                    heap_we    = 1'b1;
                    pos_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    heap_ra    = ADDR_W'(parent - SLOT_W'(1));
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (heap_q.pri > cur_reg.pri)
                begin
                    heap_wd    = heap_q;
                    pos_wa     = heap_q.id;
                    s_next     = parent;
                    state_next = S_UPRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DNRL:
            begin
                if (lslot > count_ext)
                begin
                    heap_we    = 1'b1;
                    pos_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    heap_ra    = ADDR_W'(lslot - (SLOT_W + 1)'(1));
                    state_next = S_DNRR;
                end
            end
            S_DNRR:
            begin
                left_next  = heap_q;
                rok_next   = (rslot <= count_ext);
                heap_ra    = ADDR_W'(rslot - (SLOT_W + 1)'(1));
                state_next = S_DNCMP;
            end
            S_DNCMP:
            begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (take_r)
                begin
                    heap_wd    = heap_q;
                    pos_wa     = heap_q.id;
                    s_next     = SLOT_W'(rslot);
                    state_next = S_DNRL;
                end
                else if (take_l)
                begin
                    heap_wd    = left_reg;
                    pos_wa     = left_reg.id;
                    s_next     = SLOT_W'(lslot);
                    state_next = S_DNRL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    out_id_next      = res_id_reg;
                    out_pri_next     = res_pri_reg;
                    entry_count_next = count_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            kind_reg        <= '0;
            id_reg          <= '0;
            req_reg         <= '0;
            count_reg       <= '0;
            cap_reg         <= SLOT_W'(CAPACITY);
            s_reg           <= '0;
            cur_reg         <= '0;
            left_reg        <= '0;
            rok_reg         <= 1'b0;
            res_status_reg  <= ST_OK;
            res_id_reg      <= '0;
            res_pri_reg     <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_OK;
            out_id_reg      <= '0;
            out_pri_reg     <= '0;
            entry_count_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            kind_reg        <= kind_next;
            id_reg          <= id_next;
            req_reg         <= req_next;
            count_reg       <= count_next;
            cap_reg         <= cap_next;
            s_reg           <= s_next;
            cur_reg         <= cur_next;
            left_reg        <= left_next;
            rok_reg         <= rok_next;
            res_status_reg  <= res_status_next;
            res_id_reg      <= res_id_next;
            res_pri_reg     <= res_pri_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            out_id_reg      <= out_id_next;
            out_pri_reg     <= out_pri_next;
            entry_count_reg <= entry_count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/imq_chk.sv @@
// Port-level checker for the indexed min priority queue, bound to the top level.
`default_nettype none

module imq_chk (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [imq_pkg::STATUS_W-1:0]    status,
    input wire logic signed [imq_pkg::PRI_W-1:0] out_priority,
    input wire logic [imq_pkg::SLOT_W-1:0]      entry_count
);

    import imq_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Result item dropped before it was taken.");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= SLOT_W'(CAPACITY))
        else $error("Entry count above capacity.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= STATUS_W'(ST_NOT_LOWER))
        else $error("Unknown status code.");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_W'(ST_OK) |-> out_priority == '0)
        else $error("Nonzero priority with an error status.");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_W'(ST_EMPTY) |-> entry_count == '0)
        else $error("Empty status with entries held.");

endmodule

bind indexed_min_priority_queue imq_chk u_imq_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_priority (out_priority),
    .entry_count  (entry_count)
);

`default_nettype wire
